// ----- rtl/alu8f_pkg.sv -----
package alu8f_pkg;

  localparam int CmdW = 5;

  localparam logic [CmdW-1:0] CMD_ADD  = 5'd0;
  localparam logic [CmdW-1:0] CMD_ADC  = 5'd1;
  localparam logic [CmdW-1:0] CMD_SUB  = 5'd2;
  localparam logic [CmdW-1:0] CMD_SBC  = 5'd3;
  localparam logic [CmdW-1:0] CMD_AND  = 5'd4;
  localparam logic [CmdW-1:0] CMD_XOR  = 5'd5;
  localparam logic [CmdW-1:0] CMD_OR   = 5'd6;
  localparam logic [CmdW-1:0] CMD_CP   = 5'd7;
  localparam logic [CmdW-1:0] CMD_INC  = 5'd8;
  localparam logic [CmdW-1:0] CMD_DEC  = 5'd9;
  localparam logic [CmdW-1:0] CMD_DAA  = 5'd10;
  localparam logic [CmdW-1:0] CMD_RLCA = 5'd11;
  localparam logic [CmdW-1:0] CMD_RLA  = 5'd12;
  localparam logic [CmdW-1:0] CMD_RRCA = 5'd13;
  localparam logic [CmdW-1:0] CMD_RRA  = 5'd14;
  localparam logic [CmdW-1:0] CMD_RLC  = 5'd15;
  localparam logic [CmdW-1:0] CMD_RL   = 5'd16;
  localparam logic [CmdW-1:0] CMD_RRC  = 5'd17;
  localparam logic [CmdW-1:0] CMD_RR   = 5'd18;
  localparam logic [CmdW-1:0] CMD_SLA  = 5'd19;
  localparam logic [CmdW-1:0] CMD_SRA  = 5'd20;
  localparam logic [CmdW-1:0] CMD_SRL  = 5'd21;
  localparam logic [CmdW-1:0] CMD_SWAP = 5'd22;
  localparam logic [CmdW-1:0] CMD_BIT  = 5'd23;

  localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HI_LIM  = 8'h99;
  localparam logic [3:0] DAA_LO_LIM  = 4'h9;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [7:0]      acc;
    logic [7:0]      operand;
    logic [7:0]      bit_mask;
    logic            carry_in;
    logic            half_in;
    logic            sub_in;
  } item_t;

  typedef struct packed {
    logic [7:0] result;
    logic       z;
    logic       n;
    logic       h;
    logic       c;
  } res_t;

endpackage

// ----- rtl/cpu_alu_8bit_flags_top.sv -----
// 8-bit ALU with Z/N/H/C flags and decimal adjust.
// An accepted word goes through the input register, then the result register, to out_valid.
// Throughput: one word per cycle while out_stall is low; the single ALU pass between the two registers sets it.
// The input stage is held only while it holds a word and the result register is full and stalled.
// Reset (rst, synchronous, active high) clears both valid bits; payload is not reset.
module cpu_alu_8bit_flags_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [alu8f_pkg::CmdW-1:0]  cmd,
  input  logic [7:0]                  acc,
  input  logic [7:0]                  operand,
  input  logic [7:0]                  bit_mask,
  input  logic                        carry_in,
  input  logic                        half_in,
  input  logic                        sub_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  result,
  output logic                        zero_flag,
  output logic                        subtract_flag,
  output logic                        half_carry_flag,
  output logic                        carry_flag
);
  import alu8f_pkg::*;

  logic  iv;
  item_t iq;
  res_t  res;
  logic  out_adv;
  logic  in_adv;

  assign out_adv  = !out_valid || !out_stall;
  assign in_adv   = !iv || out_adv;
  assign in_stall = !in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_adv) begin
      iv <= in_valid;
    end
    if (in_adv && in_valid) begin
      iq <= '{cmd, acc, operand, bit_mask, carry_in, half_in, sub_in};
    end
  end

  // ALU pass
  logic [8:0] sum9;
  logic [4:0] sum5;
  logic [8:0] dif9;
  logic [4:0] dif5;
  logic       ci;
  logic [7:0] daa_r;
  logic       daa_c;
  logic [7:0] a;
  logic [7:0] v;

  always_comb begin
    a  = iq.acc;
    v  = iq.operand;
    ci = ((iq.cmd == CMD_ADC) || (iq.cmd == CMD_SBC)) ? iq.carry_in : 1'b0;
    sum9 = {1'b0, a} + {1'b0, v} + {8'd0, ci};
    sum5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci};
    dif9 = {1'b0, a} - {1'b0, v} - {8'd0, ci};
    dif5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci};

    daa_r = a;
    daa_c = iq.carry_in;
    if (iq.sub_in) begin
      if (iq.carry_in) daa_r = daa_r - DAA_HI_ADJ;
      if (iq.half_in)  daa_r = daa_r - DAA_LO_ADJ;
    end else begin
      if (iq.carry_in || (a > DAA_HI_LIM)) begin
        daa_r = daa_r + DAA_HI_ADJ;
        daa_c = 1'b1;
      end
      if (iq.half_in || (a[3:0] > DAA_LO_LIM)) daa_r = daa_r + DAA_LO_ADJ;
    end

    res.result = a;
    res.n = 1'b0;
    res.h = 1'b0;
    res.c = 1'b0;
    res.z = 1'b0;
    unique case (iq.cmd)
      CMD_ADD, CMD_ADC: begin
        res.result = sum9[7:0];
        res.h = sum5[4];
        res.c = sum9[8];
      end
      CMD_SUB, CMD_SBC: begin
        res.result = dif9[7:0];
        res.n = 1'b1;
        res.h = dif5[4];
        res.c = dif9[8];
      end
      CMD_CP: begin
        res.n = 1'b1;
        res.h = dif5[4];
        res.c = dif9[8];
      end
      CMD_AND: begin
        res.result = a & v;
        res.h = 1'b1;
      end
      CMD_XOR:  res.result = a ^ v;
      CMD_OR:   res.result = a | v;
      CMD_INC: begin
        res.result = v + 8'd1;
        res.h = (v[3:0] == 4'hf);
        res.c = iq.carry_in;
      end
      CMD_DEC: begin
        res.result = v - 8'd1;
        res.n = 1'b1;
        res.h = (v[3:0] == 4'h0);
        res.c = iq.carry_in;
      end
      CMD_DAA: begin
        res.result = daa_r;
        res.n = iq.sub_in;
        res.c = daa_c;
      end
      CMD_RLCA: begin res.result = {a[6:0], a[7]};          res.c = a[7]; end
      CMD_RLA:  begin res.result = {a[6:0], iq.carry_in};   res.c = a[7]; end
      CMD_RRCA: begin res.result = {a[0], a[7:1]};          res.c = a[0]; end
      CMD_RRA:  begin res.result = {iq.carry_in, a[7:1]};   res.c = a[0]; end
      CMD_RLC:  begin res.result = {v[6:0], v[7]};          res.c = v[7]; end
      CMD_RL:   begin res.result = {v[6:0], iq.carry_in};   res.c = v[7]; end
      CMD_RRC:  begin res.result = {v[0], v[7:1]};          res.c = v[0]; end
      CMD_RR:   begin res.result = {iq.carry_in, v[7:1]};   res.c = v[0]; end
      CMD_SLA:  begin res.result = {v[6:0], 1'b0};          res.c = v[7]; end
      CMD_SRA:  begin res.result = {v[7], v[7:1]};          res.c = v[0]; end
      CMD_SRL:  begin res.result = {1'b0, v[7:1]};          res.c = v[0]; end
      CMD_SWAP: res.result = {v[3:0], v[7:4]};
      CMD_BIT: begin
        res.result = v;
        res.h = 1'b1;
        res.c = iq.carry_in;
      end
      default: begin
        // unused codes: pass acc and N/H/C through; Z follows the result
        res.n = iq.sub_in;
        res.h = iq.half_in;
        res.c = iq.carry_in;
      end
    endcase

    // Z: compare and bit test have their own sources, accumulator rotates force 0
    priority if (iq.cmd == CMD_CP) begin
      res.z = (dif9[7:0] == 8'd0);
    end else if (iq.cmd == CMD_BIT) begin
      res.z = ((v & iq.bit_mask) == 8'd0);
    end else if ((iq.cmd == CMD_RLCA) || (iq.cmd == CMD_RLA) ||
                 (iq.cmd == CMD_RRCA) || (iq.cmd == CMD_RRA)) begin
      res.z = 1'b0;
    end else begin
      res.z = (res.result == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= iv;
    end
    if (out_adv && iv) begin
      result          <= res.result;
      zero_flag       <= res.z;
      subtract_flag   <= res.n;
      half_carry_flag <= res.h;
      carry_flag      <= res.c;
    end
  end

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (iv && out_valid && out_stall))
    else $error("input stalled while result register can move");

  a_accept_fills_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> iv)
    else $error("accepted word lost in input stage");

  a_input_moves_out: assert property (@(posedge clk) disable iff (rst)
    (iv && out_adv) |=> out_valid)
    else $error("input stage word not moved to result register");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!iv && out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule
